// File: design/rrp_pkg.sv
// Package for the range reply parser: shared widths, constants and the queue entry type.
// No dependencies.
package rrp_pkg;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_PARSE_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ID = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_FUNC = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VALID_STATE = 2'd3;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Byte as classified by the front end, waiting for the parser.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_end;
      logic       is_digit;
      logic [3:0] digit_val;
   } rrp_item_type;

   // One CRC-16/MODBUS byte update, eight shift steps on 16 bits.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction
endpackage

// File: design/rrp_front.sv
// Front end of the range reply parser: accepts bytes, classifies them, and queues them.
// Depends on rrp_pkg.
module rrp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   input  logic                  req_chunk_end,
   output logic                  q_valid,
   input  logic                  q_take,
   output rrp_pkg::rrp_item_type q_item
);
   import rrp_pkg::*;

   rrp_item_type ent_ff [2];
   rrp_item_type ent_in;
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   // Classify the byte as it enters.
   always_comb begin
      ent_in.rx_byte = req_rx_byte;
      ent_in.chunk_end = req_chunk_end;
      ent_in.is_digit = (req_rx_byte >= "0") && (req_rx_byte <= "9");
      ent_in.digit_val = req_rx_byte[3:0];
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_take;
   assign q_item = ent_ff[rd_ptr_ff];

   // Two-entry queue between the front and the parser.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            ent_ff[wr_ptr_ff] <= ent_in;
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// File: design/rrp_back.sv
// Back end of the range reply parser: ASCII and Modbus parsing with the output register.
// Depends on rrp_pkg.
module rrp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_take,
   input  rrp_pkg::rrp_item_type q_item,
   input  logic                  mode_wr,
   input  logic                  parse_mode,
   input  logic [7:0]            device_id,
   input  logic [7:0]            read_func_code,
   input  logic [7:0]            valid_state_code,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_distance_mm,
   output logic [7:0]            rsp_sensor_status,
   output logic                  rsp_update,
   output logic                  rsp_chunk_done,
   output logic                  rsp_chunk_consumed
);
   import rrp_pkg::*;

   typedef enum logic [1:0] {PH_HUNT, PH_SKIP, PH_TAKE, PH_NUM} phase_type;
   localparam logic [2:0] KP_D = 3'd5;

   phase_type phase_ff, phase_in;
   logic [2:0] kp_ff, kp_in;
   logic [15:0] acc_ff, acc_in;
   logic seen_ff, seen_in;
   logic [8:0] pos_ff, pos_in;
   logic [7:0] len_ff, len_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] fd_ff, fd_in;
   logic [15:0] dist_ff, dist_in;
   logic [7:0] stat_ff, stat_in;
   logic cons_ff, cons_in;
   logic upd, cons_out;
   logic [7:0] b;
   logic [8:0] crc_lo_pos;
   logic [15:0] crc_b, crc_id;

   assign q_take = !rsp_valid || !rsp_stall;
   assign b = q_item.rx_byte;
   assign crc_lo_pos = 9'd3 + {1'b0, len_ff};
   assign crc_b = crc_byte(crc_ff, b);
   assign crc_id = crc_byte(CRC_INIT, b);

   // Keyword character expected at each position of "State".
   function automatic logic [7:0] kw_char(input logic [2:0] p);
      case (p)
         3'd1: kw_char = "t";
         3'd2: kw_char = "a";
         3'd3: kw_char = "t";
         3'd4: kw_char = "e";
         default: kw_char = "S";
      endcase
   endfunction

   // Next parser state for one byte.
   always_comb begin
      phase_in = phase_ff;
      kp_in = kp_ff;
      acc_in = acc_ff;
      seen_in = seen_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      crc_in = crc_ff;
      fd_in = fd_ff;
      dist_in = dist_ff;
      stat_in = stat_ff;
      cons_in = cons_ff;
      upd = 1'b0;
      cons_out = 1'b0;
      if (!parse_mode) begin
         logic hunt;
         hunt = 1'b0;
         case (phase_ff)
            PH_SKIP: phase_in = PH_TAKE;
            PH_TAKE: begin
               stat_in = b - "0";
               phase_in = PH_HUNT;
            end
            PH_NUM: begin
               if (q_item.is_digit) begin
                  acc_in = (acc_ff << 3) + (acc_ff << 1) + {12'd0, q_item.digit_val};
                  seen_in = 1'b1;
               end else if (!(b == " " && !seen_ff)) begin
                  if (seen_ff) begin
                     dist_in = acc_ff;
                     cons_in = 1'b1;
                     upd = 1'b1;
                  end
                  phase_in = PH_HUNT;
                  seen_in = 1'b0;
                  hunt = 1'b1;
               end
            end
            default: hunt = 1'b1;
         endcase
         // Keyword hunt; a partial digit phase always enters with progress zero.
         if (hunt) begin
            logic [2:0] p;
            p = (phase_ff == PH_NUM) ? 3'd0 : kp_ff;
            if (p >= 3'd1 && p <= 3'd4 && b == kw_char(p)) begin
               if (p == 3'd4) begin
                  phase_in = PH_SKIP;
                  kp_in = 3'd0;
               end else kp_in = p + 3'd1;
            end else if (p == KP_D && b == ":") begin
               phase_in = PH_NUM;
               seen_in = 1'b0;
               acc_in = 16'd0;
               kp_in = 3'd0;
            end else begin
               kp_in = (b == "S") ? 3'd1 : (b == "d") ? KP_D : 3'd0;
            end
         end
      end else begin
         logic restart;
         restart = 1'b0;
         if (pos_ff == 9'd0) restart = 1'b1;
         else if (pos_ff == 9'd1) begin
            if (b == read_func_code) begin
               crc_in = crc_b;
               pos_in = 9'd2;
            end else restart = 1'b1;
         end else if (pos_ff == 9'd2) begin
            len_in = b;
            crc_in = crc_b;
            fd_in = 16'd0;
            pos_in = 9'd3;
         end else if (pos_ff < crc_lo_pos) begin
            if (pos_ff < 9'd5) fd_in = {fd_ff[7:0], b};
            crc_in = crc_b;
            pos_in = pos_ff + 9'd1;
         end else if (pos_ff == crc_lo_pos) begin
            if (b == crc_ff[7:0]) pos_in = pos_ff + 9'd1;
            else restart = 1'b1;
         end else if (pos_ff == crc_lo_pos + 9'd1 && b == crc_ff[15:8]) begin
            if (len_ff >= 8'd2) begin
               dist_in = fd_ff;
               stat_in = valid_state_code;
               upd = 1'b1;
            end
            cons_in = 1'b1;
            pos_in = 9'd0;
            crc_in = CRC_INIT;
         end else restart = 1'b1;
         if (restart) begin
            if (b == device_id) begin
               pos_in = 9'd1;
               crc_in = crc_id;
            end else begin
               pos_in = 9'd0;
               crc_in = CRC_INIT;
            end
         end
      end
      // Chunk end completes a pending ASCII number, drops partial matches and reports the consumed flag.
      if (q_item.chunk_end) begin
         if (!parse_mode && phase_in == PH_NUM && seen_in) begin
            dist_in = acc_in;
            cons_in = 1'b1;
            upd = 1'b1;
         end
         cons_out = cons_in;
         cons_in = 1'b0;
         phase_in = PH_HUNT;
         kp_in = 3'd0;
         seen_in = 1'b0;
         acc_in = 16'd0;
         pos_in = 9'd0;
         crc_in = CRC_INIT;
      end
   end

   // Parser state and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         kp_ff <= 3'd0;
         acc_ff <= 16'd0;
         seen_ff <= 1'b0;
         pos_ff <= 9'd0;
         len_ff <= 8'd0;
         crc_ff <= CRC_INIT;
         fd_ff <= 16'd0;
         dist_ff <= 16'd0;
         stat_ff <= 8'd0;
         cons_ff <= 1'b0;
         rsp_valid <= 1'b0;
      end else if (mode_wr) begin
         phase_ff <= PH_HUNT;
         kp_ff <= 3'd0;
         acc_ff <= 16'd0;
         seen_ff <= 1'b0;
         pos_ff <= 9'd0;
         crc_ff <= CRC_INIT;
      end else begin
         if (q_take) rsp_valid <= q_valid;
         if (q_valid && q_take) begin
            phase_ff <= phase_in;
            kp_ff <= kp_in;
            acc_ff <= acc_in;
            seen_ff <= seen_in;
            pos_ff <= pos_in;
            len_ff <= len_in;
            crc_ff <= crc_in;
            fd_ff <= fd_in;
            dist_ff <= dist_in;
            stat_ff <= stat_in;
            cons_ff <= cons_in;
            rsp_distance_mm <= dist_in;
            rsp_sensor_status <= stat_in;
            rsp_update <= upd;
            rsp_chunk_done <= q_item.chunk_end;
            rsp_chunk_consumed <= cons_out;
         end
      end
   end
endmodule

// File: design/range_reply_parser.sv
// Top level of the range reply parser: configuration registers, front queue and parser.
// Depends on rrp_pkg, rrp_front and rrp_back.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   rx_byte, chunk_end
//   rsp      out        rsp_valid/rsp_stall   distance_mm, sensor_status, update,
//                                             chunk_done, chunk_consumed
//   csr      in         csr_write_en          csr_index, csr_wdata
//
// One byte per cycle sustained while rsp is not stalled; a byte taken on req is written into
// the two-entry queue and then parsed into the parser's output register.
// Reset is synchronous and restores the register defaults and the hunting state.
// A stall on rsp backs up the queue; req stalls only when both queue entries are full.
module range_reply_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_rx_byte,
   input  logic                           req_chunk_end,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [15:0]                    rsp_distance_mm,
   output logic [7:0]                     rsp_sensor_status,
   output logic                           rsp_update,
   output logic                           rsp_chunk_done,
   output logic                           rsp_chunk_consumed,
   input  logic                           csr_write_en,
   input  logic [rrp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rrp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rrp_pkg::*;

   logic mode_ff;
   logic [7:0] dev_ff, func_ff, vstate_ff;
   logic mode_wr;
   logic q_valid, q_take;
   rrp_item_type q_item;

   assign mode_wr = csr_write_en && (csr_index == CSR_PARSE_MODE);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         dev_ff <= 8'd1;
         func_ff <= 8'd3;
         vstate_ff <= 8'd0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PARSE_MODE: mode_ff <= csr_wdata[0];
            CSR_DEVICE_ID: dev_ff <= csr_wdata;
            CSR_READ_FUNC: func_ff <= csr_wdata;
            CSR_VALID_STATE: vstate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   rrp_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_rx_byte(req_rx_byte), .req_chunk_end(req_chunk_end),
      .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
   );

   rrp_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
      .mode_wr(mode_wr), .parse_mode(mode_ff), .device_id(dev_ff),
      .read_func_code(func_ff), .valid_state_code(vstate_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_distance_mm(rsp_distance_mm), .rsp_sensor_status(rsp_sensor_status),
      .rsp_update(rsp_update), .rsp_chunk_done(rsp_chunk_done),
      .rsp_chunk_consumed(rsp_chunk_consumed)
   );
endmodule
